>>> src/cca_pkg.sv
// Shared types, codes and calendar helpers for the calendar clock with alarm.
package cca_pkg;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ALARM_MONTH   = 3'd0;
  localparam logic [2:0] REG_ALARM_DATE    = 3'd1;
  localparam logic [2:0] REG_ALARM_WEEKDAY = 3'd2;
  localparam logic [2:0] REG_ALARM_HOUR    = 3'd3;
  localparam logic [2:0] REG_ALARM_MINUTE  = 3'd4;
  localparam logic [2:0] REG_ALARM_SECOND  = 3'd5;
  localparam logic [2:0] REG_ALARM_ENABLE  = 3'd6;
  localparam logic [2:0] REG_SHAKE_SECONDS = 3'd7;

  localparam logic [5:0] LAST_SECOND  = 6'd59;
  localparam logic [5:0] LAST_MINUTE  = 6'd59;
  localparam logic [4:0] LAST_HOUR    = 5'd23;
  localparam logic [2:0] LAST_WEEKDAY = 3'd6;
  localparam logic [3:0] LAST_MONTH   = 4'd12;
  localparam logic [3:0] SHAKE_MAX    = 4'd15;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       ringing;
    logic [3:0] shake_count;
  } clk_state_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       enable;
    logic [3:0] shake_seconds;
  } alarm_cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       inactive;
  } item_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2: len = 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

>>> src/cca_step.sv
// Next-state logic of the calendar clock for one item: carries, loads, shake and alarm.
module cca_step
  import cca_pkg::*;
(
  input  clk_state_t cur,
  input  item_t      item,
  input  alarm_cfg_t cfg,
  output clk_state_t nxt
);

  logic       sec_wrap, min_wrap, hour_wrap, date_end;
  logic [3:0] ld_month;
  logic [4:0] ld_len;
  logic [3:0] evt_count;
  logic       match;
  clk_state_t upd;

  always_comb begin
    sec_wrap  = (cur.second == LAST_SECOND);
    min_wrap  = sec_wrap && (cur.minute == LAST_MINUTE);
    hour_wrap = min_wrap && (cur.hour == LAST_HOUR);
    date_end  = (cur.date >= month_len(cur.month));

    // clamp the loaded month first; the date clamps to its length
    if (item.month == 4'd0) begin
      ld_month = 4'd1;
    end else if (item.month > LAST_MONTH) begin
      ld_month = LAST_MONTH;
    end else begin
      ld_month = item.month;
    end
    ld_len = month_len(ld_month);

    evt_count = item.inactive ? 4'd0 : cur.shake_count;

    upd = cur;
    case (item.op)
      OP_TICK: begin
        upd.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
        if (sec_wrap) begin
          upd.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
        end
        if (min_wrap) begin
          upd.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
        end
        if (hour_wrap) begin
          upd.weekday = (cur.weekday >= LAST_WEEKDAY) ? 3'd0 : cur.weekday + 3'd1;
          if (date_end) begin
            upd.date  = 5'd1;
            upd.month = (cur.month >= LAST_MONTH) ? 4'd1 : cur.month + 4'd1;
          end else begin
            upd.date = cur.date + 5'd1;
          end
        end
        // only a tick that starts while ringing counts
        if (cur.ringing && cur.shake_count != SHAKE_MAX) begin
          upd.shake_count = cur.shake_count + 4'd1;
        end
      end
      OP_LOAD: begin
        upd.month = ld_month;
        if (item.date == 5'd0) begin
          upd.date = 5'd1;
        end else if (item.date > ld_len) begin
          upd.date = ld_len;
        end else begin
          upd.date = item.date;
        end
        upd.weekday = (item.weekday > LAST_WEEKDAY) ? LAST_WEEKDAY : item.weekday;
        upd.hour    = (item.hour > LAST_HOUR) ? LAST_HOUR : item.hour;
        upd.minute  = (item.minute > LAST_MINUTE) ? LAST_MINUTE : item.minute;
        upd.second  = (item.second > LAST_SECOND) ? LAST_SECOND : item.second;
      end
      OP_EVENT: begin
        upd.shake_count = evt_count;
        if (evt_count == cfg.shake_seconds) begin
          upd.shake_count = 4'd0;
          upd.ringing     = 1'b0;
        end
      end
      default: begin
        upd = cur;
      end
    endcase

    match = (cfg.month == upd.month) && (cfg.date == upd.date) &&
            (cfg.weekday == upd.weekday) && (cfg.hour == upd.hour) &&
            (cfg.minute == upd.minute) && (cfg.second == upd.second);

    nxt = upd;
    // compare only on items that began with the alarm silent
    if (!cur.ringing && cfg.enable && match) begin
      nxt.ringing = 1'b1;
    end
  end

endmodule

>>> src/calendar_clock_with_alarm_unit.sv
// Top level of the calendar clock with alarm and shake-to-dismiss.
//
// Each accepted item (second tick, clock load or accelerometer event) gives one result
// with the clock, ringing flag and shake count after that item. The block takes one item
// per clock cycle unless the output side stalls: an item lands in an input register, and
// once the result register is free or being taken, the combinational carry, clamp and
// alarm-compare logic updates the clock state and fills the result register, which then
// offers the result. While a result waits on the output side the input register holds
// one more item, and then the input stalls until the result is taken.
// Alarm registers are written through the cfg port, one per handshake; the user must
// write them only while no item is in flight, which the block itself does not enforce.
module calendar_clock_with_alarm_unit
  import cca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // load_month[3:0], load_date[8:4], load_weekday[11:9], load_hour[16:12],
  // load_minute[22:17], load_second[28:23], inactive[29], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // month[3:0], date[8:4], weekday[11:9], hour[16:12], minute[22:17],
  // second[28:23], ringing[29], shake_count[33:30], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  alarm_cfg_t cfg;
  clk_state_t st, st_next;
  item_t      item;
  logic       in_valid;
  logic       advance;
  logic       out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.month         <= 4'd1;
      cfg.date          <= 5'd1;
      cfg.weekday       <= 3'd0;
      cfg.hour          <= 5'd0;
      cfg.minute        <= 6'd0;
      cfg.second        <= 6'd0;
      cfg.enable        <= 1'b0;
      cfg.shake_seconds <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALARM_MONTH:   cfg.month         <= cfg_data[3:0];
        REG_ALARM_DATE:    cfg.date          <= cfg_data[4:0];
        REG_ALARM_WEEKDAY: cfg.weekday       <= cfg_data[2:0];
        REG_ALARM_HOUR:    cfg.hour          <= cfg_data[4:0];
        REG_ALARM_MINUTE:  cfg.minute        <= cfg_data[5:0];
        REG_ALARM_SECOND:  cfg.second        <= cfg_data[5:0];
        REG_ALARM_ENABLE:  cfg.enable        <= cfg_data[0];
        REG_SHAKE_SECONDS: cfg.shake_seconds <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.op       <= s_axis_tuser;
      item.month    <= s_axis_tdata[3:0];
      item.date     <= s_axis_tdata[8:4];
      item.weekday  <= s_axis_tdata[11:9];
      item.hour     <= s_axis_tdata[16:12];
      item.minute   <= s_axis_tdata[22:17];
      item.second   <= s_axis_tdata[28:23];
      item.inactive <= s_axis_tdata[29];
    end
  end

  cca_step u_step (
    .cur  (st),
    .item (item),
    .cfg  (cfg),
    .nxt  (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.month       <= 4'd1;
      st.date        <= 5'd1;
      st.weekday     <= 3'd0;
      st.hour        <= 5'd0;
      st.minute      <= 6'd0;
      st.second      <= 6'd0;
      st.ringing     <= 1'b0;
      st.shake_count <= 4'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {6'd0, st_next.shake_count, st_next.ringing, st_next.second,
                   st_next.minute, st_next.hour, st_next.weekday, st_next.date,
                   st_next.month};
    end
  end

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    st.second <= LAST_SECOND && st.minute <= LAST_MINUTE && st.hour <= LAST_HOUR &&
    st.weekday <= LAST_WEEKDAY)
    else $error("clock field out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    st.month >= 4'd1 && st.month <= LAST_MONTH && st.date >= 5'd1 &&
    st.date <= month_len(st.month))
    else $error("date outside its month");

  a_ring_on_item: assert property (@(posedge clk) disable iff (rst)
    $rose(st.ringing) |-> $past(advance))
    else $error("ringing started without an item");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(item))
    else $error("pending item lost");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for the calendar clock with alarm: streams items and checks each result.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cca_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  // Predicts the clock, ringing flag and shake count after every accepted item
  class clock_scoreboard;
    alarm_cfg_t alarm;
    clk_state_t now;
    clk_state_t expected_clocks[$];
    int errors;
    int results;
    int rings;
    int dismissals;
    int op_count[4];

    function new();
      alarm = '0;
      alarm.month = 4'd1;
      alarm.date = 5'd1;
      alarm.shake_seconds = 4'd7;
      now = '0;
      now.month = 4'd1;
      now.date = 5'd1;
      errors = 0;
      results = 0;
      rings = 0;
      dismissals = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_ALARM_MONTH:   alarm.month = val[3:0];
        REG_ALARM_DATE:    alarm.date = val[4:0];
        REG_ALARM_WEEKDAY: alarm.weekday = val[2:0];
        REG_ALARM_HOUR:    alarm.hour = val[4:0];
        REG_ALARM_MINUTE:  alarm.minute = val[5:0];
        REG_ALARM_SECOND:  alarm.second = val[5:0];
        REG_ALARM_ENABLE:  alarm.enable = val[0];
        REG_SHAKE_SECONDS: alarm.shake_seconds = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [4:0] days_in_month(logic [3:0] m);
      case (m)
        4'd2: return 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
        default: return 5'd31;
      endcase
    endfunction

    function clk_state_t one_second_later(clk_state_t t);
      if (t.second != LAST_SECOND) begin
        t.second = t.second + 6'd1;
        return t;
      end
      t.second = '0;
      if (t.minute != LAST_MINUTE) begin
        t.minute = t.minute + 6'd1;
        return t;
      end
      t.minute = '0;
      if (t.hour != LAST_HOUR) begin
        t.hour = t.hour + 5'd1;
        return t;
      end
      t.hour = '0;
      t.weekday = (t.weekday == LAST_WEEKDAY) ? 3'd0 : t.weekday + 3'd1;
      if (t.date >= days_in_month(t.month)) begin
        t.date = 5'd1;
        t.month = (t.month == LAST_MONTH) ? 4'd1 : t.month + 4'd1;
      end else begin
        t.date = t.date + 5'd1;
      end
      return t;
    endfunction

    // Clamp each loaded field into its range; ringing and count stay as they are
    function clk_state_t after_load(item_t it, clk_state_t t);
      logic [4:0] last_day;
      t.month = (it.month == 4'd0) ? 4'd1 : (it.month > LAST_MONTH) ? LAST_MONTH : it.month;
      last_day = days_in_month(t.month);
      t.date = (it.date == 5'd0) ? 5'd1 : (it.date > last_day) ? last_day : it.date;
      t.weekday = (it.weekday > LAST_WEEKDAY) ? LAST_WEEKDAY : it.weekday;
      t.hour = (it.hour > LAST_HOUR) ? LAST_HOUR : it.hour;
      t.minute = (it.minute > LAST_MINUTE) ? LAST_MINUTE : it.minute;
      t.second = (it.second > LAST_SECOND) ? LAST_SECOND : it.second;
      return t;
    endfunction

    function bit alarm_hits(clk_state_t t);
      return alarm.enable && alarm.month == t.month && alarm.date == t.date &&
             alarm.weekday == t.weekday && alarm.hour == t.hour &&
             alarm.minute == t.minute && alarm.second == t.second;
    endfunction

    function void predict_clock(item_t it);
      logic was_ringing;
      was_ringing = now.ringing;
      op_count[it.op]++;
      case (it.op)
        OP_TICK: begin
          now = one_second_later(now);
          if (was_ringing && now.shake_count != SHAKE_MAX)
            now.shake_count = now.shake_count + 4'd1;
        end
        OP_LOAD: now = after_load(it, now);
        OP_EVENT: begin
          if (it.inactive) now.shake_count = '0;
          if (now.shake_count == alarm.shake_seconds) begin
            if (now.ringing) dismissals++;
            now.shake_count = '0;
            now.ringing = 1'b0;
          end
        end
        default: ;
      endcase
      // compare only on items that began with the alarm silent
      if (!was_ringing && alarm_hits(now)) begin
        now.ringing = 1'b1;
        rings++;
      end
      expected_clocks.push_back(now);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 60)
        $display("%0t: result %0d %s: got %0d, want %0d", $time, results, what, got, want);
    endtask

    task check_clock(logic [OUT_DATA_W-1:0] d);
      clk_state_t want;
      if (expected_clocks.size() == 0) begin
        report_mismatch("arrived with nothing pending", 0, 0);
        return;
      end
      want = expected_clocks.pop_front();
      results++;
      if (d[3:0] != want.month)
        report_mismatch("month", int'(d[3:0]), int'(want.month));
      if (d[8:4] != want.date)
        report_mismatch("date", int'(d[8:4]), int'(want.date));
      if (d[11:9] != want.weekday)
        report_mismatch("weekday", int'(d[11:9]), int'(want.weekday));
      if (d[16:12] != want.hour)
        report_mismatch("hour", int'(d[16:12]), int'(want.hour));
      if (d[22:17] != want.minute)
        report_mismatch("minute", int'(d[22:17]), int'(want.minute));
      if (d[28:23] != want.second)
        report_mismatch("second", int'(d[28:23]), int'(want.second));
      if (d[29] != want.ringing)
        report_mismatch("ringing", int'(d[29]), int'(want.ringing));
      if (d[33:30] != want.shake_count)
        report_mismatch("shake_count", int'(d[33:30]), int'(want.shake_count));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [2:0]            cfg_index;
  logic [7:0]            cfg_data;

  clock_scoreboard sb;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  int items_sent = 0;

  calendar_clock_with_alarm_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic item_t make_item(logic [1:0] op, logic [3:0] mo, logic [4:0] da,
                                      logic [2:0] wd, logic [4:0] hr, logic [5:0] mi,
                                      logic [5:0] se, logic inact);
    item_t it;
    it.op = op;
    it.month = mo;
    it.date = da;
    it.weekday = wd;
    it.hour = hr;
    it.minute = mi;
    it.second = se;
    it.inactive = inact;
    return it;
  endfunction

  // Mostly ticks and events; the rest loads with raw field values and the unused op
  function automatic item_t random_item(bit ticks_only);
    item_t it;
    int pick;
    it = make_item(OP_TICK, 4'($urandom), 5'($urandom), 3'($urandom), 5'($urandom),
                   6'($urandom), 6'($urandom), 1'($urandom));
    pick = ticks_only ? 0 : $urandom_range(99);
    if (pick < 62) begin
      it.op = OP_TICK;
    end else if (pick < 88) begin
      it.op = OP_EVENT;
      it.inactive = ($urandom_range(3) == 0);
    end else if (pick < 95) begin
      it.op = OP_LOAD;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (gaps_on && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {2'b00, it.inactive, it.second, it.minute, it.hour, it.weekday,
                     it.date, it.month};
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_clock(it);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  task automatic program_alarm(input logic [7:0] mo, da, wd, hr, mi, se, en, sh);
    write_reg(REG_ALARM_MONTH, mo);
    write_reg(REG_ALARM_DATE, da);
    write_reg(REG_ALARM_WEEKDAY, wd);
    write_reg(REG_ALARM_HOUR, hr);
    write_reg(REG_ALARM_MINUTE, mi);
    write_reg(REG_ALARM_SECOND, se);
    write_reg(REG_ALARM_ENABLE, en);
    write_reg(REG_SHAKE_SECONDS, sh);
    cfg_valid <= 1'b0;
  endtask

  // Drain all pending results before touching the alarm registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_clocks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVENT, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_item(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    // every field at its top code, then the new-year rollover
    send_item(make_item(OP_LOAD, 15, 31, 7, 31, 63, 63, 1));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 0));
    // February clamps to 28 and rolls into March
    send_item(make_item(OP_LOAD, 2, 31, 3, 23, 59, 59, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_LOAD, 4, 30, 6, 23, 59, 59, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_LOAD, 1, 31, 2, 23, 59, 59, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    settle();
    program_alarm(6, 15, 3, 12, 30, 0, 1, 2);
    send_item(make_item(OP_LOAD, 6, 15, 3, 12, 29, 58, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVENT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVENT, 0, 0, 0, 0, 0, 0, 0));
    // a load that lands on the alarm time rings right away
    send_item(make_item(OP_LOAD, 6, 15, 3, 12, 30, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVENT, 0, 0, 0, 0, 0, 0, 1));
    settle();
    // zero threshold: any event that finds the count at zero dismisses
    program_alarm(6, 15, 3, 12, 30, 0, 1, 0);
    send_item(make_item(OP_EVENT, 0, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin : stimulus
    item_t it;
    clk_state_t start;
    clk_state_t target;
    logic [7:0] sh;
    int phase;
    int len;
    int wait_count;
    sb = new();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ALARM_MONTH;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();

    phase = 0;
    while (items_sent < 1150) begin
      settle();
      gaps_on = (phase % 5 != 3);
      // load a start time, often just short of a day or month rollover
      it = random_item(1'b1);
      it.op = OP_LOAD;
      if ($urandom_range(1)) begin
        it.hour = 5'd23;
        it.minute = 6'd59;
        it.second = 6'($urandom_range(50, 59));
        if ($urandom_range(1)) it.date = 5'd31;
      end
      start = sb.after_load(it, sb.now);
      target = start;
      repeat ($urandom_range(0, 6)) target = sb.one_second_later(target);
      case ($urandom_range(3))
        0: sh = 8'd0;
        1: sh = 8'd15;
        default: sh = 8'($urandom_range(1, 6));
      endcase
      if (phase % 4 == 1)
        program_alarm(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        program_alarm(8'(target.month), 8'(target.date), 8'(target.weekday),
                      8'(target.hour), 8'(target.minute), 8'(target.second),
                      8'($urandom_range(7) != 0), sh);
      send_item(it);
      if (phase % 15 == 3) hold_request = 1'b1;
      len = $urandom_range(20, 60);
      for (int i = 0; i < len; i++)
        send_item(random_item(phase % 3 == 2 && i < 20));
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    wait_count = 0;
    while (sb.expected_clocks.size() != 0 && wait_count < 500) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_clocks.size() != 0)
      sb.report_mismatch("results never arrived", 0, sb.expected_clocks.size());
    $display("Ran %0d items: %0d ticks, %0d loads, %0d events, %0d unused; %0d results checked",
             items_sent, sb.op_count[OP_TICK], sb.op_count[OP_LOAD], sb.op_count[OP_EVENT],
             sb.op_count[OP_UNUSED], sb.results);
    $display("Alarm went off %0d times, shaken off %0d times, %0d mismatches",
             sb.rings, sb.dismissals, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when asked, to back up the block
  initial begin : receiver
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 11);
        @(posedge clk);
      end
    end
  end

  initial begin : monitor
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_clock(m_axis_tdata);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
